FILE: src/slcfr_pkg.sv
`timescale 1ns / 1ps
package slcfr_pkg;

  // Payload buffer depth and its address width
  localparam int BUF_DEPTH = 64;
  localparam int MEM_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Front-to-back job queue
  localparam int JQ_DEPTH  = 2;
  localparam int JQ_AW     = 1;

  // Result queue in the back part
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = 2;

  // CRC-8 generator polynomial
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Register indexes
  localparam logic CFG_SYNC_VALUE  = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;
  localparam logic [1:0] ST_CRC_ERR = 2'd3;

  // Request codes
  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_RESYNC = 1'b1;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ID   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_CRC  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_id;
    logic [6:0]  pay_len;
    logic [5:0]  byte_index;
    logic [7:0]  data_out;
    logic        last;
    logic [31:0] good_count;
    logic [31:0] error_count;
  } res_t;

  // One frame outcome handed from the front to the back
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_id;
    logic [6:0]  pay_len;
    logic [31:0] good_count;
    logic [31:0] error_count;
  } job_t;

  // Payload buffer write port
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // One CRC-8 byte update, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: src/sync_len_crc8_frame_receiver.sv
`timescale 1ns / 1ps
// With the back part idle, an error or empty-frame result passes from the job queue
// through the s1 register to the result queue; payload frames first start a buffer walk.
// Throughput: one byte per cycle in; results leave at one per cycle from a 4-deep queue.
// Input stalls on a full job queue, and payload bytes of the next frame stall while the
// back part still reads the buffer (one 64x8 memory, one write and one read port).
// Reset (rst, synchronous, active high): hunting, counters zero, registers 170 and 64.
module sync_len_crc8_frame_receiver import slcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_t        rx_item,
  output logic       empty,
  input  logic       pop,
  output res_t       result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic jq_full;
  logic jq_empty;
  logic jq_pop;
  logic job_push;
  logic busy;
  logic hold_data;
  job_t job_in;
  job_t job_out;
  wr_t  wr;

  // Hold payload writes while a frame waits for or is in its buffer walk
  assign hold_data = !jq_empty || busy;

  slcfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_item   (rx_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .jq_full   (jq_full),
    .hold_data (hold_data),
    .job_push  (job_push),
    .job       (job_in),
    .wr        (wr)
  );

  slcfr_job_queue u_jq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .full   (jq_full),
    .rd_en  (jq_pop),
    .rd_job (job_out),
    .empty  (jq_empty)
  );

  slcfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .jq_empty (jq_empty),
    .jq_job   (job_out),
    .jq_pop   (jq_pop),
    .busy     (busy),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

FILE: src/slcfr_front.sv
`timescale 1ns / 1ps
module slcfr_front import slcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_t        rx_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       jq_full,
  input  logic       hold_data,
  output logic       job_push,
  output job_t       job,
  output wr_t        wr
);

  phase_t      phase, phase_next;
  logic [7:0]  sync_value;
  logic [6:0]  max_payload;
  logic [7:0]  held_id;
  logic [6:0]  held_len;
  logic [6:0]  fill_index;
  logic [7:0]  crc_acc;
  logic [31:0] good_total, good_next;
  logic [31:0] error_total, error_next;
  logic [7:0]  b;
  logic [7:0]  crc_upd;
  logic [6:0]  limit;
  logic [6:0]  fill_inc;
  logic        accept;
  logic        is_byte;

  localparam logic [6:0] BUF_LIM = 7'(BUF_DEPTH);

  // Stall on a full job queue, or on payload writes while the buffer is read
  assign full    = jq_full || ((phase == PH_DATA) && hold_data);
  assign accept  = push && !full;
  assign b       = rx_item.rx_byte;
  assign is_byte = (rx_item.req_type == REQ_BYTE);
  assign crc_upd = crc8_step(crc_acc, b);
  assign limit   = (max_payload < BUF_LIM) ? max_payload : BUF_LIM;
  assign fill_inc = fill_index + 7'd1;

  // Classify the byte against the current phase
  always_comb begin
    phase_next = phase;
    good_next  = good_total;
    error_next = error_total;
    job_push   = 1'b0;
    job        = '0;
    wr         = '0;
    if (accept && is_byte) begin
      unique case (phase)
        PH_ID: phase_next = PH_LEN;
        PH_LEN: begin
          if (b > {1'b0, limit}) begin
            error_next       = error_total + 32'd1;
            job_push         = 1'b1;
            job.status       = ST_LEN_ERR;
            job.pay_len      = b[7] ? 7'd127 : b[6:0];
            phase_next       = PH_HUNT;
          end else begin
            phase_next = (b == 8'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          wr.en   = 1'b1;
          wr.addr = fill_index[MEM_AW-1:0];
          wr.data = b;
          if (fill_inc >= held_len) phase_next = PH_CRC;
        end
        PH_CRC: begin
          job_push    = 1'b1;
          job.pay_len = held_len;
          if (b == crc_acc) begin
            good_next  = good_total + 32'd1;
            job.status = (held_len == 7'd0) ? ST_EMPTY : ST_PAYLOAD;
            if (held_len == 7'd0) job.pay_len = 7'd0;
          end else begin
            error_next = error_total + 32'd1;
            job.status = ST_CRC_ERR;
          end
          phase_next = PH_HUNT;
        end
        default: phase_next = (b == sync_value) ? PH_ID : PH_HUNT;
      endcase
      job.frame_id    = held_id;
      job.good_count  = good_next;
      job.error_count = error_next;
    end else if (accept) begin
      phase_next = PH_HUNT;
    end
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value  <= 8'd170;
      max_payload <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYNC_VALUE) sync_value <= cfg_data;
      else max_payload <= cfg_data[6:0];
    end
  end

  // Advance frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_id     <= 8'd0;
      held_len    <= 7'd0;
      fill_index  <= 7'd0;
      crc_acc     <= 8'd0;
      good_total  <= 32'd0;
      error_total <= 32'd0;
    end else if (accept) begin
      phase       <= phase_next;
      good_total  <= good_next;
      error_total <= error_next;
      if (!is_byte) begin
        fill_index <= 7'd0;
        crc_acc    <= 8'd0;
      end else begin
        unique case (phase)
          PH_ID: begin
            held_id <= b;
            crc_acc <= crc_upd;
          end
          PH_LEN: begin
            crc_acc <= crc_upd;
            if (b <= {1'b0, limit}) begin
              held_len   <= b[6:0];
              fill_index <= 7'd0;
            end
          end
          PH_DATA: begin
            crc_acc    <= crc_upd;
            fill_index <= fill_inc;
          end
          PH_CRC: ;
          default: if (b == sync_value) crc_acc <= 8'd0;
        endcase
      end
    end
  end

  // Never write the buffer while the back part still reads it
  a_no_write_on_hold: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !hold_data) else $error("payload write while buffer is read");
  // A job is only pushed into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !jq_full) else $error("job pushed into full queue");
  // Payload fill never runs past the declared length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (fill_index < held_len)) else $error("fill past length");

endmodule

FILE: src/slcfr_job_queue.sv
`timescale 1ns / 1ps
module slcfr_job_queue import slcfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic empty
);

  job_t             slots [JQ_DEPTH];
  logic [JQ_AW-1:0] wptr;
  logic [JQ_AW-1:0] rptr;
  logic [JQ_AW:0]   count;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count == (JQ_AW + 1)'(JQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rptr];

  // Store the job
  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      count <= count + (JQ_AW + 1)'(do_wr) - (JQ_AW + 1)'(do_rd);
    end
  end

endmodule

FILE: src/slcfr_back.sv
`timescale 1ns / 1ps
module slcfr_back import slcfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  wr_t  wr,
  input  logic jq_empty,
  input  job_t jq_job,
  output logic jq_pop,
  output logic busy,
  output logic empty,
  input  logic pop,
  output res_t result
);

  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       rd_data;
  logic             run_active;
  job_t             run_job;
  logic [6:0]       run_k;
  logic             run_last;
  logic             s1_valid;
  logic             s1_from_mem;
  res_t             s1_res;
  res_t             oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wptr;
  logic [OQ_AW-1:0] oq_rptr;
  logic [OQ_AW:0]   oq_count;
  logic [OQ_AW+1:0] occupancy;
  logic             credit;
  logic             issue_run;
  logic             take_job;
  logic             do_pop;
  res_t             s1_out;

  assign occupancy = {1'b0, oq_count} + (OQ_AW + 2)'(s1_valid);
  assign credit    = (occupancy < (OQ_AW + 2)'(OQ_DEPTH));
  assign issue_run = credit && run_active;
  assign take_job  = credit && !run_active && !jq_empty;
  assign jq_pop    = take_job;
  assign busy      = run_active;
  assign run_last  = ((run_k + 7'd1) == run_job.pay_len);
  assign empty     = (oq_count == '0);
  assign do_pop    = pop && !empty;
  assign result    = oq[oq_rptr];

  // Payload buffer: written by the front, read one byte per issue
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    if (issue_run) rd_data <= mem[run_k[MEM_AW-1:0]];
  end

  // Walk a good frame's payload, or pass a single-result job
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_k      <= 7'd0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= issue_run || (take_job && (jq_job.status != ST_PAYLOAD));
      if (take_job && (jq_job.status == ST_PAYLOAD)) begin
        run_active <= 1'b1;
        run_k      <= 7'd0;
      end else if (issue_run) begin
        run_k <= run_k + 7'd1;
        if (run_last) run_active <= 1'b0;
      end
    end
  end

  // Result metadata for the read in flight
  always_ff @(posedge clk) begin
    if (take_job) run_job <= jq_job;
    if (issue_run) begin
      s1_from_mem       <= 1'b1;
      s1_res.status     <= ST_PAYLOAD;
      s1_res.frame_id   <= run_job.frame_id;
      s1_res.pay_len    <= run_job.pay_len;
      s1_res.byte_index <= run_k[5:0];
      s1_res.data_out   <= 8'd0;
      s1_res.last       <= run_last;
      s1_res.good_count <= run_job.good_count;
      s1_res.error_count <= run_job.error_count;
    end else if (take_job) begin
      s1_from_mem       <= 1'b0;
      s1_res.status     <= jq_job.status;
      s1_res.frame_id   <= jq_job.frame_id;
      s1_res.pay_len    <= jq_job.pay_len;
      s1_res.byte_index <= 6'd0;
      s1_res.data_out   <= 8'd0;
      s1_res.last       <= 1'b1;
      s1_res.good_count <= jq_job.good_count;
      s1_res.error_count <= jq_job.error_count;
    end
  end

  // Merge read data into the result
  always_comb begin
    s1_out = s1_res;
    if (s1_from_mem) s1_out.data_out = rd_data;
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (s1_valid) oq[oq_wptr] <= s1_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (s1_valid) oq_wptr <= oq_wptr + 1'b1;
      if (do_pop) oq_rptr <= oq_rptr + 1'b1;
      oq_count <= oq_count + (OQ_AW + 1)'(s1_valid) - (OQ_AW + 1)'(do_pop);
    end
  end

  // Result queue never overflows
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= (OQ_AW + 1)'(OQ_DEPTH)) else $error("result queue overflow");
  // A payload walk stays inside the frame
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_active |-> (run_k < run_job.pay_len)) else $error("payload walk past length");
  // The final byte of a walk ends the run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (issue_run && run_last) |=> !run_active) else $error("run did not end");

endmodule
